// ===== hdl/zcpt_pkg.sv =====
// Shared constants and types for the zero-crossing pitch tracker.
`default_nettype none

package zcpt_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int COUNT_BITS  = 24;
    localparam int RATE_BITS   = 18;
    localparam int FRAC_BITS   = 8;
    localparam int PITCH_BITS  = RATE_BITS + FRAC_BITS;

    localparam int IN_TDATA_BITS  = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_BITS = ((PITCH_BITS + 7) / 8) * 8;

    localparam logic [RATE_BITS-1:0] RATE_RESET = RATE_BITS'(48000);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    localparam int STEP_BITS = $clog2(PITCH_BITS);

    // One classified sample, handed from the front end to the divider side.
    typedef struct packed {
        logic                  is_div;
        logic [COUNT_BITS-1:0] divisor;
    } job_t;

    typedef struct packed {
        logic full;
        logic valid;
    } queue_status_t;

endpackage

`default_nettype wire

// ===== hdl/zcpt_front.sv =====
// Front end: takes samples, detects rising crossings, tracks the period count.
`default_nettype none

module zcpt_front (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [zcpt_pkg::IN_TDATA_BITS-1:0] s_tdata,
    input  wire logic                            q_full,
    output logic                                 push,
    output zcpt_pkg::job_t                       push_job
);
    import zcpt_pkg::*;

    logic signed [SAMPLE_BITS-1:0] prev_reg, prev_next;
    logic [COUNT_BITS-1:0]         count_reg, count_next;
    logic signed [SAMPLE_BITS-1:0] smp;
    logic                          rising;
    logic                          accept;

    assign smp      = $signed(s_tdata[SAMPLE_BITS-1:0]);
    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign rising   = (prev_reg <= 0) && (smp > 0);

    assign push             = accept;
    assign push_job.is_div  = rising && (count_reg != '0);
    assign push_job.divisor = count_reg;

    always_comb
    begin
        prev_next  = prev_reg;
        count_next = count_reg;
        if (accept)
        begin
            prev_next = smp;
            if (rising)
            begin
                count_next = '0;
            end
            else if (count_reg != {COUNT_BITS{1'b1}})
            begin
                count_next = count_reg + COUNT_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            prev_reg  <= prev_next;
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/zcpt_queue.sv =====
// Short job queue between the front end and the divider side.
`default_nettype none

module zcpt_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire zcpt_pkg::job_t push_job,
    input  wire logic           pop,
    output zcpt_pkg::job_t      head_job,
    output zcpt_pkg::queue_status_t status
);
    import zcpt_pkg::*;

    job_t                 slot_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_BITS-1:0] cnt_reg, cnt_next;
    logic                 do_wr, do_rd;

    assign status.full  = (cnt_reg == QCNT_BITS'(QUEUE_DEPTH));
    assign status.valid = (cnt_reg != '0);
    assign head_job     = slot_reg[rd_ptr_reg];

    assign do_wr = push && !status.full;
    assign do_rd = pop && status.valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                        : wr_ptr_reg + QPTR_BITS'(1);
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                        : rd_ptr_reg + QPTR_BITS'(1);
        end
        cnt_next = cnt_reg + QCNT_BITS'(do_wr) - QCNT_BITS'(do_rd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/zcpt_back.sv =====
// Back end: bit-serial restoring divider, held pitch and output register.
`default_nettype none

module zcpt_back (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic [zcpt_pkg::RATE_BITS-1:0]    sample_rate,
    input  wire zcpt_pkg::queue_status_t           q_status,
    input  wire zcpt_pkg::job_t                    head_job,
    output logic                                   pop,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [zcpt_pkg::OUT_TDATA_BITS-1:0]    m_tdata
);
    import zcpt_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_DONE = 3'b100
    } back_state_t;

    back_state_t           state_reg, state_next;
    logic [COUNT_BITS:0]   rem_reg, rem_next;
    logic [PITCH_BITS-1:0] num_reg, num_next;
    logic [COUNT_BITS-1:0] div_reg, div_next;
    logic [STEP_BITS-1:0]  step_reg, step_next;
    logic [PITCH_BITS-1:0] held_reg, held_next;
    logic                  out_valid_reg, out_valid_next;
    logic [PITCH_BITS-1:0] out_data_reg, out_data_next;

    logic [COUNT_BITS:0]   rem_sh;
    logic [COUNT_BITS+1:0] diff;
    logic                  ge;
    logic                  out_free;

    // One restoring step: shift in the next numerator bit, try the subtract.
    assign rem_sh = {rem_reg[COUNT_BITS-1:0], num_reg[PITCH_BITS-1]};
    assign diff   = {1'b0, rem_sh} - {2'b00, div_reg};
    assign ge     = !diff[COUNT_BITS+1];

    assign out_free = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_TDATA_BITS'(out_data_reg);

    always_comb
    begin
        state_next     = state_reg;
        rem_next       = rem_reg;
        num_next       = num_reg;
        div_next       = div_reg;
        step_next      = step_reg;
        held_next      = held_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        pop            = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_status.valid && (head_job.is_div || out_free))
                begin
                    pop = 1'b1;
                    if (head_job.is_div)
                    begin
                        rem_next   = '0;
                        num_next   = {sample_rate, {FRAC_BITS{1'b0}}};
                        div_next   = head_job.divisor;
                        step_next  = STEP_BITS'(PITCH_BITS - 1);
                        state_next = ST_DIV;
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                        out_data_next  = held_reg;
                    end
                end
            end
            ST_DIV:
            begin
                rem_next  = ge ? diff[COUNT_BITS:0] : rem_sh;
                num_next  = {num_reg[PITCH_BITS-2:0], ge};
                step_next = step_reg - STEP_BITS'(1);
                if (step_reg == '0)
                begin
                    held_next  = {num_reg[PITCH_BITS-2:0], ge};
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = held_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            held_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            held_reg      <= held_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg      <= rem_next;
        num_reg      <= num_next;
        div_reg      <= div_next;
        step_reg     <= step_next;
        out_data_reg <= out_data_next;
    end

endmodule

`default_nettype wire

// ===== hdl/zero_crossing_pitch_tracker.sv =====
// Top level of the zero-crossing pitch tracker.
`default_nettype none

// Zero-crossing pitch tracker. Every sample transaction on the slave side
// yields exactly one pitch transaction on the master side, in order: the
// held pitch in Hz as unsigned Q18.8, 0 until the first measurement. A
// rising crossing (previous sample <= 0, current > 0) with a nonzero period
// count measures pitch = (sample_rate << 8) / count and clears the count;
// other samples bump the count, which saturates. A measuring sample runs
// through the bit-serial restoring divider (26 quotient bits, one per
// cycle, plus load and hand-off); a sample that does not measure skips
// the divider. A two-entry job queue sits between the crossing detector
// and the divider, so samples keep being taken while a division runs
// until the queue fills. sample_rate (reset 48000) may only be written
// while the block is idle.
module zero_crossing_pitch_tracker (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // sample rate register write
    input  wire logic                                cfg_we,
    input  wire logic [zcpt_pkg::RATE_BITS-1:0]      cfg_wdata,
    // slave side
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [zcpt_pkg::IN_TDATA_BITS-1:0]  s_tdata,   // [15:0] sample
    // master side
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [zcpt_pkg::OUT_TDATA_BITS-1:0]      m_tdata    // [25:0] pitch_q8, rest 0
);
    import zcpt_pkg::*;

    logic [RATE_BITS-1:0] rate_reg, rate_next;
    logic                 push;
    job_t                 push_job;
    job_t                 head_job;
    logic                 pop;
    queue_status_t        q_status;

    // Config register; no read-back.
    assign rate_next = cfg_we ? cfg_wdata : rate_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg <= RATE_RESET;
        end
        else
        begin
            rate_reg <= rate_next;
        end
    end

    // Crossing detection and period counting.
    zcpt_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_full   (q_status.full),
        .push     (push),
        .push_job (push_job)
    );

    // Decouples the detector from the divider.
    zcpt_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .status   (q_status)
    );

    // Divider, held pitch and output register.
    zcpt_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .sample_rate (rate_reg),
        .q_status    (q_status),
        .head_job    (head_job),
        .pop         (pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    // Backpressure toward the source only when jobs are waiting.
    a_stall_has_jobs: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> q_status.valid)
        else $error("slave side stalled with an empty job queue");

    // The back end never pops an empty queue.
    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_status.valid)
        else $error("job popped from empty queue");

    // A full queue that is not drained stays full on the next edge.
    a_full_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (q_status.full && !pop) |=> q_status.full)
        else $error("job queue lost an entry");

endmodule

`default_nettype wire
